>>> design/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; every other design file imports this package.
package mbps_pkg;

  // Sizing
  localparam int PATTERN_MAX  = 64;
  localparam int OFFSET_BITS  = 32;
  localparam int LEN_IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LENGTH_W     = 7;
  localparam int ENTRY_IDX_W  = 6;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  // Item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH  = 2'd0,
    REG_MATCH_LIMIT     = 2'd1,
    REG_CANDIDATE_COUNT = 2'd2
  } cfg_reg_t;

  // Input item
  typedef struct packed {
    logic                   operation;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [7:0]             entry_value;
    logic                   entry_exact;
    logic [7:0]             data_byte;
    logic                   data_readable;
    logic                   stream_last;
  } scan_item_t;

  // Result item
  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic        scan_done;
    logic [31:0] next_candidate;
    logic        short_input;
  } result_item_t;

  // Settings the report stage needs
  typedef struct packed {
    logic [31:0] match_limit;
    logic [31:0] candidate_count;
  } cfg_t;

  // One scanned byte after the cell row
  typedef struct packed {
    logic                   matched;
    logic                   last;
    logic                   below_len;
    logic [OFFSET_BITS-1:0] cand;
    logic [OFFSET_BITS-1:0] covered;
  } stage1_t;

endpackage

>>> design/mbps_cell.sv
// One pattern position: stored pattern byte, exact flag and partial-match bit.
// Depends on mbps_pkg. Instantiated once per position by the top level.
module mbps_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_en,
  input  logic [7:0] entry_value,
  input  logic       entry_exact,
  input  logic       shift_en,
  input  logic       clear,
  input  logic [7:0] data_byte,
  input  logic       data_readable,
  input  logic       prev_in,
  output logic       partial,
  output logic       partial_next
);
  import mbps_pkg::*;

  logic [7:0] value;
  logic       exact;

  // Pattern storage, written by load transfers only
  always_ff @(posedge clk) begin
    if (load_en) begin
      value <= entry_value;
      exact <= entry_exact;
    end
  end

  // Extend the neighbor's partial match by this byte
  assign partial_next = prev_in && data_readable && (!exact || data_byte == value);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= 1'b0;
    end else if (clear) begin
      partial <= 1'b0;
    end else if (shift_en) begin
      partial <= partial_next;
    end
  end

endmodule

>>> design/mbps_report.sv
// Report stage: candidate window checks, match counting, stop state and the
// result output register. Depends on mbps_pkg.
module mbps_report (
  input  logic                   clk,
  input  logic                   rst,
  input  mbps_pkg::cfg_t         cfg,
  input  logic                   s1_valid,
  input  mbps_pkg::stage1_t      s1,
  output logic                   advance,
  output logic                   result_valid,
  input  logic                   result_stall,
  output mbps_pkg::result_item_t result_item
);
  import mbps_pkg::*;

  logic         stopped;
  logic [31:0]  reported;
  logic         active;
  logic         shrt;
  logic         report;
  logic [31:0]  reported_inc;
  logic         hit;
  logic         res_valid;
  result_item_t res;
  logic         stopped_next;
  logic [31:0]  reported_next;

  // Output register takes a new value when empty or being drained
  assign advance = !result_valid || !result_stall;

  // Window and limit checks for the byte leaving the cell row
  always_comb begin
    active       = cfg.match_limit != 32'd0;
    shrt         = s1.last && active && cfg.candidate_count != 32'd0 &&
                   (s1.below_len || cfg.candidate_count > s1.covered);
    report       = s1.matched && active && (s1.cand < cfg.candidate_count) && !shrt;
    reported_inc = reported + 32'd1;
    hit          = report && (reported_inc >= cfg.match_limit);
  end

  // Result selection and stop/count bookkeeping
  always_comb begin
    res_valid     = 1'b0;
    res           = '0;
    stopped_next  = stopped;
    reported_next = reported;
    if (stopped) begin
      if (s1.last) begin
        stopped_next  = 1'b0;
        reported_next = 32'd0;
      end
    end else begin
      if (report) begin
        reported_next = reported_inc;
      end
      if (hit) begin
        res_valid          = 1'b1;
        res.match_found    = 1'b1;
        res.match_offset   = s1.cand;
        res.scan_done      = 1'b1;
        res.next_candidate = s1.cand + 32'd1;
        if (s1.last) begin
          reported_next = 32'd0;
        end else begin
          stopped_next = 1'b1;
        end
      end else if (s1.last) begin
        res_valid          = 1'b1;
        res.match_found    = report;
        res.match_offset   = report ? s1.cand : 32'd0;
        res.scan_done      = 1'b1;
        res.next_candidate = (!active || shrt) ? 32'd0 : cfg.candidate_count;
        res.short_input    = shrt;
        reported_next      = 32'd0;
      end else if (report) begin
        res_valid        = 1'b1;
        res.match_found  = 1'b1;
        res.match_offset = s1.cand;
      end
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped  <= 1'b0;
      reported <= 32'd0;
    end else if (s1_valid && advance) begin
      stopped  <= stopped_next;
      reported <= reported_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item <= res;
    end
  end

endmodule

>>> design/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner: configuration registers,
// stream position, the row of pattern cells and the report stage.
// Depends on mbps_pkg, mbps_cell and mbps_report.
//
// Load transfers write one pattern position; scan transfers push one stream
// byte through a row of 64 cells that each compare the byte with their own
// pattern entry and pass a partial-match bit to the next cell. One item is
// taken every clock cycle while scan_stall is low. The cell-row outcome of
// a scan byte is registered in the stage-1 register and its result in the
// report stage's output register. A stall on the result side holds the input
// back only once both the report stage and the output register are full.
// Configuration writes are always ready and are meant for idle periods
// between streams. There is no clearing pass after reset: pattern entries
// must be loaded before use.
module masked_byte_pattern_scanner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 scan_valid,
  output logic                                 scan_stall,
  input  mbps_pkg::scan_item_t                 scan_item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output mbps_pkg::result_item_t               result_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mbps_pkg::*;

  logic [LENGTH_W-1:0]    pattern_length;
  cfg_t                   cfg;
  logic [OFFSET_BITS-1:0] position;
  logic [LENGTH_W-1:0]    used_len;
  logic [LEN_IDX_W-1:0]   len_m1;
  logic                   accept;
  logic                   scan_en;
  logic                   load_en;
  logic [PATTERN_MAX-1:0] partial;
  logic [PATTERN_MAX-1:0] partial_next;
  logic                   s1_valid;
  stage1_t                s1;
  stage1_t                s1_next;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] len_m1_ext;
  logic                   advance;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length      <= LENGTH_W'(1);
      cfg.match_limit     <= 32'd1;
      cfg.candidate_count <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LENGTH:  pattern_length      <= cfg_data[LENGTH_W-1:0];
        REG_MATCH_LIMIT:     cfg.match_limit     <= cfg_data[31:0];
        REG_CANDIDATE_COUNT: cfg.candidate_count <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    if (pattern_length == '0) begin
      used_len = LENGTH_W'(1);
    end else if (pattern_length > LENGTH_W'(PATTERN_MAX)) begin
      used_len = LENGTH_W'(PATTERN_MAX);
    end else begin
      used_len = pattern_length;
    end
  end
  assign len_m1     = LEN_IDX_W'(used_len - LENGTH_W'(1));
  assign len_m1_ext = OFFSET_BITS'(len_m1);

  // Input handshake
  assign scan_stall = s1_valid && !advance;
  assign accept     = scan_valid && !scan_stall;
  assign scan_en    = accept && (scan_item.operation == OP_SCAN);
  assign load_en    = accept && (scan_item.operation == OP_LOAD);

  // Row of pattern cells
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = partial[k-1];
    end
    mbps_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .load_en       (load_en && (32'(scan_item.entry_index) == 32'(k))),
      .entry_value   (scan_item.entry_value),
      .entry_exact   (scan_item.entry_exact),
      .shift_en      (scan_en && (32'(k) <= 32'(len_m1))),
      .clear         (scan_en && scan_item.stream_last),
      .data_byte     (scan_item.data_byte),
      .data_readable (scan_item.data_readable),
      .prev_in       (prev),
      .partial       (partial[k]),
      .partial_next  (partial_next[k])
    );
  end

  // Stream position, back to zero after the last byte
  assign pos_inc = position + OFFSET_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (scan_en) begin
      position <= scan_item.stream_last ? '0 : pos_inc;
    end
  end

  // Candidate offset and coverage of the byte entering the report stage
  always_comb begin
    s1_next.matched   = partial_next[len_m1];
    s1_next.last      = scan_item.stream_last;
    s1_next.below_len = pos_inc < len_m1_ext;
    s1_next.cand      = position - len_m1_ext;
    s1_next.covered   = pos_inc - len_m1_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || advance) begin
      s1_valid <= scan_en;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en) begin
      s1 <= s1_next;
    end
  end

  // Report stage and output register
  mbps_report u_report (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

>>> design/mbps_checker.sv
// Port-level checks for the masked byte pattern scanner, bound to the top.
// Depends on mbps_pkg and masked_byte_pattern_scanner.
module mbps_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_stall,
  input mbps_pkg::result_item_t result_item
);
  import mbps_pkg::*;

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // Every result reports a match or the end of the scan
  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.match_found || result_item.scan_done)
    else $error("result with neither match nor done");

  // Offset is zero without a match
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.match_found |-> result_item.match_offset == 32'd0)
    else $error("offset set without a match");

  // Done fields are clear on a plain match
  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.scan_done |->
      result_item.next_candidate == 32'd0 && !result_item.short_input)
    else $error("done fields set on a match-only result");

  // A short stream never reports a match and gives no next candidate
  a_short: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.short_input |->
      !result_item.match_found && result_item.next_candidate == 32'd0)
    else $error("short stream result carries a match");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
